/* hdl/vpw_frame_symbol_encoder_unit_macros.svh */
// assertion macros for the vpw frame symbol encoder
`ifndef VPW_FRAME_SYMBOL_ENCODER_UNIT_MACROS_SVH
`define VPW_FRAME_SYMBOL_ENCODER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VPWENC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vpw encoder check failed");

// antecedent implies consequent in the next cycle
`define VPWENC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vpw encoder check failed");

`endif

/* hdl/vpwenc_pkg.sv */
// shared types, constants and crc function for the vpw frame symbol encoder
package vpwenc_pkg;

  typedef enum logic [1:0] {
    SYM_LONG  = 2'd0,
    SYM_SHORT = 2'd1,
    SYM_SOF   = 2'd2,
    SYM_EOF   = 2'd3
  } sym_t;

  localparam logic [7:0] CRC_POLY   = 8'h1D;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] CRC_XOROUT = 8'hFF;

  localparam int MAX_SYMS = 18;
  localparam int CNT_W    = $clog2(MAX_SYMS + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] symbol;
    logic       last_symbol;
  } out_t;

  typedef struct packed {
    logic       in_frame;
    logic       prev_bit;
    logic       prev_sym;
    logic [7:0] crc;
  } state_t;

  typedef logic [MAX_SYMS-1:0][1:0] sym_vec_t;

  localparam state_t STATE_RESET = '{
    in_frame: 1'b0,
    prev_bit: 1'b1,
    prev_sym: 1'b1,
    crc:      CRC_INIT
  };

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

/* hdl/vpw_frame_symbol_encoder_unit.sv */
// Frame byte to VPW symbol encoder. Each accepted byte yields 8 symbols, 9 when it opens a
// frame (start-of-frame first), 17 when it closes one (eight crc-8 symbols and end-of-frame
// follow), 18 for a one-byte frame, delivered one per cycle while out_ready is high; the
// final symbol of each byte carries last_symbol. A byte is registered on input, expanded
// in one pass into an 18-entry symbol shift register together with the frame state
// update, and the shift register then drains one symbol per cycle while out_ready is high,
// so a byte holds the block until its symbol list has drained. The next byte is taken into
// the input register while the current list drains and is loaded the cycle the last symbol
// leaves, so output symbols run without gaps. On an idle block a byte passes through the
// input register and then the symbol shift register before its first symbol appears.
`include "vpw_frame_symbol_encoder_unit_macros.svh"

module vpw_frame_symbol_encoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vpwenc_pkg::in_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vpwenc_pkg::out_t   out_data
);

  logic                           hold_valid;
  vpwenc_pkg::in_t                hold;
  vpwenc_pkg::state_t             state;
  vpwenc_pkg::state_t             state_next;
  vpwenc_pkg::sym_vec_t           sym_buf;
  vpwenc_pkg::sym_vec_t           gen_syms;
  logic [vpwenc_pkg::CNT_W-1:0]   cnt;
  logic [vpwenc_pkg::CNT_W-1:0]   gen_count;
  logic                           take;
  logic                           load;

  vpwenc_symgen u_symgen (
    .item       (hold),
    .state      (state),
    .syms       (gen_syms),
    .count      (gen_count),
    .state_next (state_next)
  );

  assign out_valid = (cnt != '0);
  assign take      = out_valid && out_ready;
  // refill when empty or as the final symbol leaves
  assign load      = hold_valid
                  && ((cnt == '0) || ((cnt == vpwenc_pkg::CNT_W'(1)) && out_ready));
  assign in_ready  = !hold_valid || load;

  assign out_data.symbol      = sym_buf[0];
  assign out_data.last_symbol = (cnt == vpwenc_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vpwenc_pkg::STATE_RESET;
      cnt   <= '0;
    end else if (load) begin
      state <= state_next;
      cnt   <= gen_count;
    end else if (take) begin
      cnt   <= cnt - vpwenc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sym_buf <= gen_syms;
    end else if (take) begin
      sym_buf <= {2'b00, sym_buf[vpwenc_pkg::MAX_SYMS-1:1]};
    end
  end

  `VPWENC_ASSERT_SAME(a_sof_not_last, out_valid && out_data.last_symbol, out_data.symbol != vpwenc_pkg::SYM_SOF)
  `VPWENC_ASSERT_SAME(a_eof_is_last, out_valid && (out_data.symbol == vpwenc_pkg::SYM_EOF), out_data.last_symbol)
  `VPWENC_ASSERT_NEXT(a_close_frame, load && hold.last_byte, !state.in_frame && (cnt >= vpwenc_pkg::CNT_W'(17)))

endmodule

/* hdl/vpwenc_symgen.sv */
// builds the full symbol list for one byte and the frame state that follows it
module vpwenc_symgen (
  input  vpwenc_pkg::in_t                      item,
  input  vpwenc_pkg::state_t                   state,
  output vpwenc_pkg::sym_vec_t                 syms,
  output logic [vpwenc_pkg::CNT_W-1:0]         count,
  output vpwenc_pkg::state_t                   state_next
);

  vpwenc_pkg::state_t     start;
  logic                   sof;
  logic [7:0]             crc_new;
  logic [15:0]            bits;
  logic [15:0]            chain;
  logic [16:0][1:0]       body;
  logic                   pb;
  logic                   ps;

  // a closed frame restarts from the reset chain and crc
  assign sof   = !state.in_frame;
  assign start = sof ? vpwenc_pkg::STATE_RESET : state;

  assign crc_new = vpwenc_pkg::crc8_update(start.crc, item.data_byte);
  assign bits    = {item.data_byte, crc_new ^ vpwenc_pkg::CRC_XOROUT};

  // toggle on repeated bit, msb first, data then crc
  always_comb begin
    pb = start.prev_bit;
    ps = start.prev_sym;
    for (int i = 0; i < 16; i++) begin
      if (bits[15-i] == pb) begin
        ps = ~ps;
      end
      pb       = bits[15-i];
      chain[i] = ps;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      body[i] = {1'b0, chain[i]};
    end
    body[16] = vpwenc_pkg::SYM_EOF;
    if (sof) begin
      syms = {body, vpwenc_pkg::SYM_SOF};
    end else begin
      syms = {2'b00, body};
    end
  end

  always_comb begin
    count = vpwenc_pkg::CNT_W'(8) + vpwenc_pkg::CNT_W'(sof)
          + (item.last_byte ? vpwenc_pkg::CNT_W'(9) : vpwenc_pkg::CNT_W'(0));
  end

  always_comb begin
    if (item.last_byte) begin
      state_next = vpwenc_pkg::STATE_RESET;
    end else begin
      state_next.in_frame = 1'b1;
      state_next.prev_bit = item.data_byte[0];
      state_next.prev_sym = chain[7];
      state_next.crc      = crc_new;
    end
  end

endmodule
